// ===== rtl/dark_bright_channel_window_defines.svh =====
// assertion macros for the dark/bright channel window block
`ifndef DARK_BRIGHT_CHANNEL_WINDOW_DEFINES_SVH
`define DARK_BRIGHT_CHANNEL_WINDOW_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DBCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DBCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dbcw_pkg.sv =====
// shared constants and types of the dark/bright channel window block
package dbcw_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WINDOW = 15;
	localparam int ROW_SLOTS  = MAX_WINDOW + 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SLOT_W     = $clog2(ROW_SLOTS);
	localparam int ADDR_W     = COL_W + SLOT_W;
	localparam int DIM_W      = 11;
	localparam int WIN_W      = 4;
	localparam int POS_W      = DIM_W + 2;
	localparam int PIX_W      = 8;
	localparam int ENTRY_W    = 2 * PIX_W;

	localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic FUNC_PIXEL = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;
endpackage

// ===== rtl/dbcw_line_ram.sv =====
// single-port-write, single-port-read line store memory with registered read
module dbcw_line_ram #(
	parameter int AW = 14,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== rtl/dark_bright_channel_window.sv =====
// top level: window minimum/maximum of channels over a line store
// a window is scanned in ST_SCAN, then ST_FLUSH, then ST_DONE loads the output register
// throughput: one request per cycle in idle; a request releasing a result holds off requests
// while the single line store read port is scanned one entry a cycle and the output is busy
// reset: counters zero, registers 15/640/480; line store is not cleared (never read unwritten)
`include "dark_bright_channel_window_defines.svh"
module dark_bright_channel_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // chan0, chan1, chan2
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // dark_value, bright_value
	output logic        m_axis_tlast,  // frame_last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_wdata
);
	localparam int DW = dbcw_pkg::DIM_W;
	localparam int PW = dbcw_pkg::POS_W;
	localparam int WW = dbcw_pkg::WIN_W;
	localparam int XW = dbcw_pkg::PIX_W;

	dbcw_pkg::state_t state_q;

	logic [WW-1:0] ws_q;
	logic [DW-1:0] wd_q, ht_q;
	logic [DW-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic [WW-1:0] wi_q, wj_q;
	logic [XW-1:0] mn_q, mx_q;
	logic          rd_s1, oob_s1;
	logic          m_valid_q, m_last_q;
	logic [XW-1:0] m_dark_q, m_bright_q;

	logic [WW-1:0] ws, pad, ahead;
	logic [DW-1:0] wd, ht;
	logic [DW-1:0] in_row_nx, in_col_nx;
	logic [DW:0]   lr, lc;
	logic          accept, do_write, ready, out_over, last;
	logic [PW-1:0] rr, cc;
	logic          in_img;
	logic [dbcw_pkg::ADDR_W-1:0]  waddr, raddr;
	logic [dbcw_pkg::ENTRY_W-1:0] rdata, wentry;
	logic [XW-1:0] a, b, c, pmin, pmax;

	always_comb begin
		ws = (ws_q == '0) ? WW'(1) : ws_q;
		wd = (wd_q == '0) ? DW'(1) :
			(wd_q > DW'(dbcw_pkg::MAX_WIDTH)) ? DW'(dbcw_pkg::MAX_WIDTH) : wd_q;
		ht = (ht_q == '0) ? DW'(1) :
			(ht_q > DW'(dbcw_pkg::MAX_HEIGHT)) ? DW'(dbcw_pkg::MAX_HEIGHT) : ht_q;
		pad   = ws >> 1;
		ahead = ws - WW'(1) - pad;
	end

	assign s_axis_tready = (state_q == dbcw_pkg::ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign do_write = accept && (s_axis_tuser == dbcw_pkg::FUNC_PIXEL) && (in_row_q < ht);

	// per-pixel channel min and max
	always_comb begin
		a = s_axis_tdata[7:0];
		b = s_axis_tdata[15:8];
		c = s_axis_tdata[23:16];
		pmin = a;
		pmax = a;
		if (b < pmin) pmin = b;
		if (c < pmin) pmin = c;
		if (b > pmax) pmax = b;
		if (c > pmax) pmax = c;
		wentry = {pmax, pmin};
		waddr = {in_row_q[dbcw_pkg::SLOT_W-1:0], in_col_q[dbcw_pkg::COL_W-1:0]};
	end

	always_comb begin
		in_row_nx = in_row_q;
		in_col_nx = in_col_q;
		if (do_write) begin
			if (in_col_q + DW'(1) >= wd) begin
				in_col_nx = '0;
				in_row_nx = in_row_q + DW'(1);
			end else begin
				in_col_nx = in_col_q + DW'(1);
			end
		end
		out_over = (out_row_q >= ht) || (out_col_q >= wd);
		lr = {1'b0, out_row_q} + (DW+1)'(ahead);
		if (lr > {1'b0, ht - DW'(1)}) lr = {1'b0, ht - DW'(1)};
		lc = {1'b0, out_col_q} + (DW+1)'(ahead);
		if (lc > {1'b0, wd - DW'(1)}) lc = {1'b0, wd - DW'(1)};
		ready = ({1'b0, in_row_nx} > lr) ||
			(({1'b0, in_row_nx} == lr) && ({1'b0, in_col_nx} > lc));
		last = (out_row_q == ht - DW'(1)) && (out_col_q == wd - DW'(1));
	end

	// window position under scan
	always_comb begin
		rr = PW'(out_row_q) + PW'(wi_q) - PW'(pad);
		cc = PW'(out_col_q) + PW'(wj_q) - PW'(pad);
		in_img = !rr[PW-1] && !cc[PW-1] && (rr < PW'(ht)) && (cc < PW'(wd));
		raddr = {rr[dbcw_pkg::SLOT_W-1:0], cc[dbcw_pkg::COL_W-1:0]};
	end

	dbcw_line_ram #(
		.AW(dbcw_pkg::ADDR_W),
		.DW(dbcw_pkg::ENTRY_W)
	) u_line_ram (
		.clk(clk),
		.we(do_write),
		.waddr(waddr),
		.wdata(wentry),
		.re((state_q == dbcw_pkg::ST_SCAN) && in_img),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dbcw_pkg::ST_IDLE;
			ws_q      <= WW'(15);
			wd_q      <= DW'(640);
			ht_q      <= DW'(480);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			wi_q      <= '0;
			wj_q      <= '0;
			mn_q      <= '0;
			mx_q      <= '0;
			rd_s1     <= 1'b0;
			oob_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == dbcw_pkg::ST_DONE) && (!m_valid_q || m_axis_tready))
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			rd_s1  <= (state_q == dbcw_pkg::ST_SCAN) && in_img;
			oob_s1 <= (state_q == dbcw_pkg::ST_SCAN) && !in_img;
			if (oob_s1)
				mn_q <= '0;
			if (rd_s1) begin
				if (rdata[XW-1:0] < mn_q) mn_q <= rdata[XW-1:0];
				if (rdata[2*XW-1:XW] > mx_q) mx_q <= rdata[2*XW-1:XW];
			end
			if (cfg_we) begin
				case (cfg_index)
					dbcw_pkg::REG_WINDOW_SIZE:  ws_q <= cfg_wdata[WW-1:0];
					dbcw_pkg::REG_IMAGE_WIDTH:  wd_q <= cfg_wdata;
					dbcw_pkg::REG_IMAGE_HEIGHT: ht_q <= cfg_wdata;
					default: ;
				endcase
				if (cfg_index <= dbcw_pkg::REG_IMAGE_HEIGHT) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end
			end else begin
				case (state_q)
					dbcw_pkg::ST_IDLE: begin
						if (accept) begin
							if (out_over) begin
								in_row_q  <= '0;
								in_col_q  <= '0;
								out_row_q <= '0;
								out_col_q <= '0;
							end else begin
								in_row_q <= in_row_nx;
								in_col_q <= in_col_nx;
								if (ready) begin
									wi_q    <= '0;
									wj_q    <= '0;
									mn_q    <= '1;
									mx_q    <= '0;
									state_q <= dbcw_pkg::ST_SCAN;
								end
							end
						end
					end
					dbcw_pkg::ST_SCAN: begin
						if (wj_q == ws - WW'(1)) begin
							wj_q <= '0;
							wi_q <= wi_q + WW'(1);
							if (wi_q == ws - WW'(1))
								state_q <= dbcw_pkg::ST_FLUSH;
						end else begin
							wj_q <= wj_q + WW'(1);
						end
					end
					dbcw_pkg::ST_FLUSH: state_q <= dbcw_pkg::ST_DONE;
					dbcw_pkg::ST_DONE: begin
						if (!m_valid_q || m_axis_tready) begin
							if (last) begin
								in_row_q  <= '0;
								in_col_q  <= '0;
								out_row_q <= '0;
								out_col_q <= '0;
							end else if (out_col_q + DW'(1) >= wd) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + DW'(1);
							end else begin
								out_col_q <= out_col_q + DW'(1);
							end
							state_q <= dbcw_pkg::ST_IDLE;
						end
					end
					default: state_q <= dbcw_pkg::ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == dbcw_pkg::ST_DONE) && (!m_valid_q || m_axis_tready)) begin
			m_dark_q   <= mn_q;
			m_bright_q <= mx_q;
			m_last_q   <= last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_bright_q, m_dark_q};
	assign m_axis_tlast  = m_last_q;

	`DBCW_ASSERT_NOW(a_scan_in_window, state_q == dbcw_pkg::ST_SCAN, (wi_q < ws) && (wj_q < ws), "scan index left the window")
	`DBCW_ASSERT_NEXT(a_done_loads, (state_q == dbcw_pkg::ST_DONE) && !m_valid_q, m_axis_tvalid && (state_q == dbcw_pkg::ST_IDLE), "finished result not presented")
	`DBCW_ASSERT_NOW(a_no_read_when_idle, rd_s1 || oob_s1, state_q == dbcw_pkg::ST_SCAN || state_q == dbcw_pkg::ST_FLUSH, "window read outside scan")
endmodule
